// ===== sv/i2c_master_write_read_sequencer_defines.svh =====
// assertion macros for the i2c write-then-read sequencer checker
// expects clk and arst_n in the scope where a macro is used
`ifndef I2C_MASTER_WRITE_READ_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_WRITE_READ_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define I2CWRS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CWRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/i2c_wrseq_pkg.sv =====
// shared types and constants of the i2c write-then-read sequencer
// no dependencies; used by the top level, the checker and the testbench
package i2c_wrseq_pkg;

	localparam int unsigned WRITE_DEPTH_DEFAULT = 8;
	localparam logic [6:0]  DEV_ADDR_RESET      = 7'd37;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_EVENT = 2'd2;

	localparam logic [7:0] STATUS_MASK    = 8'hF8;
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RSTART      = 8'h10;
	localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
	localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
	localparam logic [7:0] ST_ARB_LOST    = 8'h38;
	localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
	localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
	localparam logic [7:0] ST_NO_INFO     = 8'hF8;

	typedef enum logic [1:0] {
		XS_IDLE_OK   = 2'd0,
		XS_IDLE_FAIL = 2'd1,
		XS_BUSY      = 2'd2
	} xfer_status_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] byte_index;
		logic [7:0] write_byte;
		logic [3:0] write_count;
		logic [7:0] read_count;
		logic [7:0] status_code;
		logic [7:0] received_byte;
		logic       stop_pending;
	} item_t;

	typedef struct packed {
		logic       release_bus;
		logic       drive_start;
		logic       drive_stop;
		logic       ack_enable;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       read_valid;
		logic [7:0] read_position;
		logic [7:0] read_data;
		logic [1:0] transfer_result;
		logic       start_rejected;
	} result_t;

endpackage

// ===== sv/i2c_wrseq_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module i2c_wrseq_ram #(
	parameter int unsigned WIDTH  = 8,
	parameter int unsigned DEPTH  = 8,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/i2c_master_write_read_sequencer.sv =====
// top level of the i2c master write-then-read sequencer
// depends on i2c_wrseq_pkg and i2c_wrseq_ram
//
// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------
// item     | item_valid / item_stall    | item   (i2c_wrseq_pkg::item_t)
// result   | result_valid / result_stall| result (i2c_wrseq_pkg::result_t)
// config   | cfg_wr_en                  | cfg_wr_data (device address)
//
// one item per cycle while item_stall is low; a result is offered once its item has passed
// the input register and then the result register; the write store read is registered
// at the edge the item is taken
// reset clears control state only; the write store is not cleared
// item_stall rises only while both registers are full and the result is stalled
module i2c_master_write_read_sequencer #(
	parameter int unsigned WRITE_DEPTH = i2c_wrseq_pkg::WRITE_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [6:0]            cfg_wr_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  i2c_wrseq_pkg::item_t   item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output i2c_wrseq_pkg::result_t result
);

	import i2c_wrseq_pkg::*;

	localparam int unsigned ADDR_W  = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
	localparam logic [7:0]  DEPTH_B = 8'(WRITE_DEPTH);

	logic              item_take;
	logic              adv;
	logic              valid_s1;
	item_t             item_s1;
	logic              res_valid_s2;
	result_t           res_s2;
	result_t           res_nx;

	logic [6:0]        dev_addr_q;
	xfer_status_t      status_q, status_nx;
	logic [3:0]        wwant_q, wwant_nx;
	logic [7:0]        rwant_q, rwant_nx;
	logic [7:0]        bpos_q, bpos_nx, bpos_now;
	logic [7:0]        bpos_inc;
	logic [3:0]        wcnt_sat;
	logic [7:0]        code_s1;

	logic [7:0]        load_idx;
	logic              st_wr_en;
	logic [ADDR_W-1:0] st_rd_addr;
	logic [7:0]        st_rd_data;

	assign item_stall = valid_s1 & res_valid_s2 & result_stall;
	assign item_take  = item_valid & ~item_stall;
	assign adv        = valid_s1 & (~res_valid_s2 | ~result_stall);

	// write store: loads land at the transfer edge, reads are taken there too
	assign load_idx   = {5'd0, item.byte_index};
	assign st_wr_en   = item_take & (item.mode == MODE_LOAD) & (load_idx < DEPTH_B);
	assign bpos_now   = adv ? bpos_nx : bpos_q;
	assign st_rd_addr = ((item.status_code & STATUS_MASK) == ST_ADDR_W_ACK) ?
		'0 : bpos_now[ADDR_W-1:0];

	i2c_wrseq_ram #(
		.WIDTH  (8),
		.DEPTH  (WRITE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (load_idx[ADDR_W-1:0]),
		.wr_data (item.write_byte),
		.rd_en   (item_take),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	assign code_s1  = item_s1.status_code & STATUS_MASK;
	assign bpos_inc = (bpos_q == 8'hFF) ? bpos_q : bpos_q + 8'd1;
	assign wcnt_sat = ({4'd0, item_s1.write_count} > DEPTH_B) ?
		DEPTH_B[3:0] : item_s1.write_count;

	always_comb begin
		res_nx            = '0;
		res_nx.ack_enable = 1'b1;
		status_nx         = status_q;
		wwant_nx          = wwant_q;
		rwant_nx          = rwant_q;
		bpos_nx           = bpos_q;
		unique case (item_s1.mode)
			MODE_START: begin
				if ((item_s1.write_count == 4'd0 && item_s1.read_count == 8'd0) ||
					status_q == XS_BUSY || item_s1.stop_pending) begin
					res_nx.start_rejected = 1'b1;
				end else begin
					wwant_nx           = wcnt_sat;
					rwant_nx           = item_s1.read_count;
					status_nx          = XS_BUSY;
					res_nx.release_bus = 1'b1;
					res_nx.drive_start = 1'b1;
				end
			end
			MODE_EVENT: begin
				unique case (code_s1)
					ST_START, ST_RSTART: begin
						res_nx.release_bus = 1'b1;
						res_nx.send_valid  = 1'b1;
						res_nx.send_byte   = {dev_addr_q, (wwant_q == 4'd0)};
					end
					ST_ADDR_W_ACK: begin
						res_nx.release_bus = 1'b1;
						res_nx.send_valid  = 1'b1;
						res_nx.send_byte   = st_rd_data;
						bpos_nx            = 8'd1;
					end
					ST_DATA_W_ACK: begin
						res_nx.release_bus = 1'b1;
						if (bpos_q >= {4'd0, wwant_q}) begin
							if (rwant_q == 8'd0) begin
								res_nx.drive_stop = 1'b1;
								status_nx         = XS_IDLE_OK;
							end else begin
								wwant_nx           = 4'd0;
								res_nx.drive_start = 1'b1;
							end
						end else begin
							res_nx.send_valid = 1'b1;
							res_nx.send_byte  = st_rd_data;
							bpos_nx           = bpos_inc;
						end
					end
					ST_ARB_LOST: begin
						res_nx.release_bus = 1'b1;
						res_nx.drive_start = 1'b1;
					end
					ST_ADDR_R_ACK: begin
						res_nx.release_bus = 1'b1;
						bpos_nx            = 8'd0;
						res_nx.ack_enable  = (rwant_q > 8'd1);
					end
					ST_DATA_R_ACK: begin
						res_nx.release_bus   = 1'b1;
						res_nx.read_valid    = 1'b1;
						res_nx.read_position = bpos_q;
						res_nx.read_data     = item_s1.received_byte;
						bpos_nx              = bpos_inc;
						res_nx.ack_enable    = ({1'b0, bpos_inc} + 9'd1 < {1'b0, rwant_q});
					end
					ST_DATA_R_NACK: begin
						res_nx.release_bus   = 1'b1;
						res_nx.read_valid    = 1'b1;
						res_nx.read_position = bpos_q;
						res_nx.read_data     = item_s1.received_byte;
						bpos_nx              = bpos_inc;
						res_nx.drive_stop    = 1'b1;
						status_nx            = XS_IDLE_OK;
					end
					ST_NO_INFO: begin
					end
					default: begin
						res_nx.release_bus = 1'b1;
						res_nx.drive_stop  = 1'b1;
						status_nx          = XS_IDLE_FAIL;
					end
				endcase
			end
			default: begin
			end
		endcase
		res_nx.transfer_result = status_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
			dev_addr_q   <= DEV_ADDR_RESET;
			status_q     <= XS_IDLE_OK;
			wwant_q      <= 4'd0;
			rwant_q      <= 8'd0;
			bpos_q       <= 8'd0;
		end else begin
			if (item_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_s2 <= 1'b1;
				status_q     <= status_nx;
				wwant_q      <= wwant_nx;
				rwant_q      <= rwant_nx;
				bpos_q       <= bpos_nx;
			end else if (!result_stall) begin
				res_valid_s2 <= 1'b0;
			end
			if (cfg_wr_en) begin
				dev_addr_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
		if (adv) begin
			res_s2 <= res_nx;
		end
	end

	assign result_valid = res_valid_s2;
	assign result       = res_s2;

endmodule

// ===== sv/i2c_wrseq_chk.sv =====
// port-level checker for the i2c write-then-read sequencer, bound to the top
// depends on i2c_wrseq_pkg and i2c_master_write_read_sequencer_defines.svh
`include "i2c_master_write_read_sequencer_defines.svh"

module i2c_wrseq_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_wr_en,
	input logic [6:0]             cfg_wr_data,
	input logic                   item_valid,
	input logic                   item_stall,
	input i2c_wrseq_pkg::item_t   item,
	input logic                   result_valid,
	input logic                   result_stall,
	input i2c_wrseq_pkg::result_t result
);

	import i2c_wrseq_pkg::*;

	`I2CWRS_ASSERT_IMPL(a_stall_only_when_full, item_stall, result_valid && result_stall, "input stalled while result side free")
	`I2CWRS_ASSERT_NEXT(a_result_follows, (item_valid && !item_stall) ##1 !result_stall, result_valid, "transfer taken but no result")
	`I2CWRS_ASSERT_IMPL(a_stop_leaves_idle, result_valid && result.drive_stop, result.transfer_result != XS_BUSY, "stop requested while busy")
	`I2CWRS_ASSERT_IMPL(a_reject_no_action, result_valid && result.start_rejected, !result.release_bus && !result.drive_start, "rejected start drove the bus")

endmodule

bind i2c_master_write_read_sequencer i2c_wrseq_chk u_i2c_wrseq_chk (.*);

// ===== dv/tb.sv =====
// testbench of the i2c master write-then-read sequencer: load, start and bus status transfers
// are predicted by a scoreboard class and each result transfer is checked field by field
// depends on i2c_wrseq_pkg and the i2c_master_write_read_sequencer top level
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2c_wrseq_pkg::*;

	localparam int unsigned STORE_DEPTH = WRITE_DEPTH_DEFAULT;
	localparam logic [1:0] MODE_UNUSED  = 2'd3;
	localparam logic [7:0] ST_BUS_ERROR = 8'h00;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 180;

	class wrseq_scoreboard;
		logic [6:0]   dev_addr;
		xfer_status_t status;
		logic [3:0]   writes_wanted;
		logic [7:0]   reads_wanted;
		logic [7:0]   byte_pos;
		logic [7:0]   store [STORE_DEPTH];
		result_t      expected_q [$];
		int           errors;

		function new();
			dev_addr = DEV_ADDR_RESET;
			status = XS_IDLE_OK;
			writes_wanted = '0;
			reads_wanted = '0;
			byte_pos = '0;
			errors = 0;
		endfunction

		function logic [7:0] store_byte(logic [7:0] idx);
			if (idx < STORE_DEPTH)
				return store[idx];
			return 8'h00;
		endfunction

		function void bump_pos();
			if (byte_pos != 8'hFF)
				byte_pos++;
		endfunction

		function result_t predict(item_t it);
			result_t    r;
			logic [7:0] code;
			r = '0;
			r.ack_enable = 1'b1;
			code = it.status_code & STATUS_MASK;
			case (it.mode)
				MODE_LOAD: begin
					if (it.byte_index < STORE_DEPTH)
						store[it.byte_index] = it.write_byte;
				end
				MODE_START: begin
					if ((it.write_count == 0 && it.read_count == 0) || status == XS_BUSY
							|| it.stop_pending) begin
						r.start_rejected = 1'b1;
					end else begin
						writes_wanted = (it.write_count > STORE_DEPTH) ? 4'(STORE_DEPTH)
							: it.write_count;
						reads_wanted = it.read_count;
						status = XS_BUSY;
						r.release_bus = 1'b1;
						r.drive_start = 1'b1;
					end
				end
				MODE_EVENT: begin
					case (code)
						ST_START, ST_RSTART: begin
							r.release_bus = 1'b1;
							r.send_valid = 1'b1;
							r.send_byte = {dev_addr, writes_wanted == 0};
						end
						ST_ADDR_W_ACK: begin
							r.release_bus = 1'b1;
							r.send_valid = 1'b1;
							r.send_byte = store_byte(8'd0);
							byte_pos = 8'd1;
						end
						ST_DATA_W_ACK: begin
							r.release_bus = 1'b1;
							if (byte_pos >= writes_wanted) begin
								if (reads_wanted == 0) begin
									r.drive_stop = 1'b1;
									status = XS_IDLE_OK;
								end else begin
									writes_wanted = '0;
									r.drive_start = 1'b1;
								end
							end else begin
								r.send_valid = 1'b1;
								r.send_byte = store_byte(byte_pos);
								bump_pos();
							end
						end
						ST_ARB_LOST: begin
							r.release_bus = 1'b1;
							r.drive_start = 1'b1;
						end
						ST_ADDR_R_ACK: begin
							r.release_bus = 1'b1;
							byte_pos = '0;
							r.ack_enable = reads_wanted > 1;
						end
						ST_DATA_R_ACK: begin
							r.release_bus = 1'b1;
							r.read_valid = 1'b1;
							r.read_position = byte_pos;
							r.read_data = it.received_byte;
							bump_pos();
							r.ack_enable = (int'(byte_pos) + 1) < int'(reads_wanted);
						end
						ST_DATA_R_NACK: begin
							r.release_bus = 1'b1;
							r.read_valid = 1'b1;
							r.read_position = byte_pos;
							r.read_data = it.received_byte;
							bump_pos();
							r.drive_stop = 1'b1;
							status = XS_IDLE_OK;
						end
						ST_NO_INFO: begin
						end
						default: begin
							r.release_bus = 1'b1;
							r.drive_stop = 1'b1;
							status = XS_IDLE_FAIL;
						end
					endcase
				end
				default: begin
				end
			endcase
			r.transfer_result = status;
			return r;
		endfunction

		function void note_item(item_t it);
			expected_q.push_back(predict(it));
		endfunction

		function void compare(string name, logic [7:0] exp_v, logic [7:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result transfer with no transfer waiting: %h", got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			compare("release_bus", exp_r.release_bus, got.release_bus);
			compare("drive_start", exp_r.drive_start, got.drive_start);
			compare("drive_stop", exp_r.drive_stop, got.drive_stop);
			compare("ack_enable", exp_r.ack_enable, got.ack_enable);
			compare("send_valid", exp_r.send_valid, got.send_valid);
			compare("send_byte", exp_r.send_byte, got.send_byte);
			compare("read_valid", exp_r.read_valid, got.read_valid);
			compare("read_position", exp_r.read_position, got.read_position);
			compare("read_data", exp_r.read_data, got.read_data);
			compare("transfer_result", exp_r.transfer_result, got.transfer_result);
			compare("start_rejected", exp_r.start_rejected, got.start_rejected);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [6:0] cfg_wr_data = '0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	item_t      item = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;

	wrseq_scoreboard sb = new();

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int items_sent = 0;
	int cycle_count = 0;

	i2c_master_write_read_sequencer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// result side: check accepted transfers, random stall, long hold on request
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	function automatic item_t rand_item();
		logic [63:0] bits;
		item_t       it;
		bits = {$urandom, $urandom};
		it = bits[$bits(item_t)-1:0];
		return it;
	endfunction

	function automatic item_t event_item(logic [7:0] code);
		item_t it;
		it = rand_item();
		it.mode = MODE_EVENT;
		it.status_code = code | 8'($urandom_range(7));
		return it;
	endfunction

	function automatic item_t start_item(logic [3:0] wcnt, logic [7:0] rcnt);
		item_t it;
		it = rand_item();
		it.mode = MODE_START;
		it.write_count = wcnt;
		it.read_count = rcnt;
		it.stop_pending = 1'b0;
		return it;
	endfunction

	function automatic item_t load_item(logic [2:0] idx, logic [7:0] data);
		item_t it;
		it = rand_item();
		it.mode = MODE_LOAD;
		it.byte_index = idx;
		it.write_byte = data;
		return it;
	endfunction

	function automatic logic [7:0] unknown_code();
		logic [7:0] c;
		c = 8'($urandom) & STATUS_MASK;
		case (c)
			ST_START, ST_RSTART, ST_ADDR_W_ACK, ST_DATA_W_ACK, ST_ARB_LOST,
			ST_ADDR_R_ACK, ST_DATA_R_ACK, ST_DATA_R_NACK, ST_NO_INFO:
				c = ST_BUS_ERROR;
			default: begin
			end
		endcase
		return c;
	endfunction

	task automatic send_item(item_t x);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(x);
		items_sent++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_address(logic [6:0] addr);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= addr;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.dev_addr = addr;
	endtask

	task automatic run_transaction();
		int nw;
		int nr;
		int wr;
		nw = ($urandom_range(7) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
		nr = ($urandom_range(7) == 0) ? $urandom_range(40, 5) : $urandom_range(4);
		if (nw == 0 && nr == 0)
			nr = 1;
		wr = (nw > STORE_DEPTH) ? STORE_DEPTH : nw;
		repeat ($urandom_range(3))
			send_item(load_item(3'($urandom), 8'($urandom)));
		send_item(start_item(4'(nw), 8'(nr)));
		// start while busy
		if ($urandom_range(9) == 0)
			send_item(start_item(4'($urandom_range(15)), 8'($urandom)));
		send_item(event_item(ST_START));
		if (wr > 0) begin
			send_item(event_item(ST_ADDR_W_ACK));
			for (int i = 0; i < wr; i++) begin
				if ($urandom_range(39) == 0) begin
					send_item(event_item(unknown_code()));
					return;
				end
				if ($urandom_range(19) == 0)
					send_item(event_item(ST_NO_INFO));
				send_item(event_item(ST_DATA_W_ACK));
			end
			if (nr == 0)
				return;
			send_item(event_item(ST_RSTART));
		end
		if ($urandom_range(7) == 0) begin
			send_item(event_item(ST_ARB_LOST));
			send_item(event_item(ST_START));
		end
		send_item(event_item(ST_ADDR_R_ACK));
		for (int i = 1; i <= nr; i++)
			send_item(event_item((i == nr) ? ST_DATA_R_NACK : ST_DATA_R_ACK));
	endtask

	task automatic run_phase(int tx_idle, int rx_idle, bit mid_pause);
		int first;
		tx_idle_pct = tx_idle;
		rx_stall_pct <= rx_idle;
		first = items_sent;
		while (items_sent - first < PHASE_ITEMS) begin
			if (mid_pause && items_sent - first >= PHASE_ITEMS / 2) begin
				mid_pause = 1'b0;
				drain();
			end
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(3, 1)) send_item(rand_item());
			else
				run_transaction();
		end
	endtask

	// read past the position limit
	task automatic long_read();
		send_item(event_item(ST_BUS_ERROR));
		send_item(start_item(4'd0, 8'd255));
		send_item(event_item(ST_START));
		send_item(event_item(ST_ADDR_R_ACK));
		repeat (258) send_item(event_item(ST_DATA_R_ACK));
		send_item(event_item(ST_DATA_R_NACK));
	endtask

	initial begin
		item_t it;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole write store first
		for (int i = 0; i < STORE_DEPTH; i++)
			send_item(load_item(3'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom)));
		send_item(start_item(4'd0, 8'd0));
		it = start_item(4'd1, 8'd2);
		it.stop_pending = 1'b1;
		send_item(it);
		send_item(start_item(4'd1, 8'd2));
		send_item(start_item(4'd8, 8'd1));
		send_item(event_item(ST_START));
		send_item(event_item(ST_ADDR_W_ACK));
		send_item(event_item(ST_DATA_W_ACK));
		send_item(event_item(ST_RSTART));
		send_item(event_item(ST_ARB_LOST));
		send_item(event_item(ST_RSTART));
		send_item(event_item(ST_ADDR_R_ACK));
		send_item(event_item(ST_DATA_R_ACK));
		send_item(event_item(ST_DATA_R_NACK));
		it = rand_item();
		it.mode = MODE_UNUSED;
		send_item(it);
		send_item(event_item(ST_NO_INFO));
		send_item(event_item(ST_BUS_ERROR));

		drain();
		write_address(7'h7F);
		hold_token <= hold_token + 1;
		run_phase(0, 0, 1'b0);
		drain();
		write_address(7'h00);
		run_phase(75, 0, 1'b1);
		drain();
		write_address(7'($urandom));
		run_phase(0, 75, 1'b0);
		drain();
		write_address(DEV_ADDR_RESET);
		run_phase(31, 31, 1'b0);
		long_read();
		drain();
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== i2c_master_write_read_sequencer.f =====
+incdir+sv
sv/i2c_wrseq_pkg.sv
sv/i2c_wrseq_ram.sv
sv/i2c_master_write_read_sequencer.sv
sv/i2c_wrseq_chk.sv
dv/tb.sv
